FILE: rtl/fadd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fadd_pkg
// Shared types and constants of the fraction add and reduce block.
// ----------------------------------------------------------------------------
package fadd_pkg;

  localparam int NumOutW = 32;
  localparam int DenOutW = 30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_ABS,
    ST_STRIP,
    ST_GCD,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MUL_A,
    OP_MUL_B,
    OP_MUL_C,
    OP_ABS,
    OP_STRIP,
    OP_GCD,
    OP_DIV_NUM,
    OP_DIV_DEN,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic last;
  } ctrl_t;

  typedef struct packed {
    logic zero;
    logic strip_done;
    logic gcd_done;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/fadd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fadd_dp
// Datapath: operand capture, multiplier, and one shared subtractor used for
// the binary gcd and for both restoring divisions.
// ----------------------------------------------------------------------------
module fadd_dp #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire fadd_pkg::ctrl_t               ctrl_i,
  input  wire logic [OPERAND_WIDTH-1:0]      num_a_i,
  input  wire logic [OPERAND_WIDTH-2:0]      den_a_i,
  input  wire logic [OPERAND_WIDTH-1:0]      num_b_i,
  input  wire logic [OPERAND_WIDTH-2:0]      den_b_i,
  output fadd_pkg::stat_t                    stat_o,
  output logic [fadd_pkg::NumOutW-1:0]       sum_num_o,
  output logic [fadd_pkg::DenOutW-1:0]       sum_den_o
);
  import fadd_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = W - 1;
  localparam int PW = 2 * W;
  localparam int MW = PW - 1;

  logic signed [W-1:0]  na_q, nb_q;
  logic [DW-1:0]        da_q, db_q;
  logic signed [W-1:0]  mul_x, mul_y;
  logic signed [PW-1:0] prod, prod_q, acc_q, acc_neg, num_s;
  logic [MW-1:0]        a_q, a_d, b_q, b_d, mag_q, mag_d, den_q, den_d;
  logic [MW-1:0]        rem_q, rem_d, quo_q, quo_d, quo_step;
  logic                 neg_q, neg_d;
  logic [MW:0]          rpart, sub_x, sub_y, sub_r;
  logic                 ge;
  logic [NumOutW-1:0]   sum_num_q;
  logic [DenOutW-1:0]   sum_den_q;

  // multiplier operand select
  always_comb begin
    unique case (ctrl_i.op)
      OP_MUL_A: begin
        mul_x = na_q;
        mul_y = signed'({1'b0, db_q});
      end
      OP_MUL_B: begin
        mul_x = nb_q;
        mul_y = signed'({1'b0, da_q});
      end
      default: begin
        mul_x = signed'({1'b0, da_q});
        mul_y = signed'({1'b0, db_q});
      end
    endcase
  end

  assign prod    = PW'(mul_x) * PW'(mul_y);
  assign acc_neg = -acc_q;

  // shared subtractor
  assign rpart    = {rem_q, quo_q[MW-1]};
  assign sub_x    = (ctrl_i.op == OP_GCD) ? {1'b0, a_q} : rpart;
  assign sub_y    = {1'b0, b_q};
  assign sub_r    = sub_x - sub_y;
  assign ge       = ~sub_r[MW];
  assign quo_step = {quo_q[MW-2:0], ge};

  assign stat_o.zero       = (acc_q == '0);
  assign stat_o.strip_done = a_q[0] | b_q[0];
  assign stat_o.gcd_done   = (a_q == '0);

  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    mag_d = mag_q;
    den_d = den_q;
    rem_d = rem_q;
    quo_d = quo_q;
    neg_d = neg_q;
    unique case (ctrl_i.op)
      OP_ABS: begin
        if (stat_o.zero) begin
          mag_d = '0;
          den_d = MW'(1);
          neg_d = 1'b0;
        end else begin
          a_d   = acc_q[PW-1] ? acc_neg[MW-1:0] : acc_q[MW-1:0];
          b_d   = prod_q[MW-1:0];
          neg_d = acc_q[PW-1];
        end
      end
      OP_STRIP: begin
        if (!stat_o.strip_done) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
        end else begin
          mag_d = a_q;
          den_d = b_q;
        end
      end
      OP_GCD: begin
        priority if (stat_o.gcd_done) begin
          quo_d = mag_q;
          rem_d = '0;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (!ge) begin
          a_d = b_q;
          b_d = a_q;
        end else begin
          a_d = sub_r[MW-1:0];
        end
      end
      OP_DIV_NUM: begin
        rem_d = ge ? sub_r[MW-1:0] : rpart[MW-1:0];
        quo_d = quo_step;
        if (ctrl_i.last) begin
          mag_d = quo_step;
          quo_d = den_q;
          rem_d = '0;
        end
      end
      OP_DIV_DEN: begin
        rem_d = ge ? sub_r[MW-1:0] : rpart[MW-1:0];
        quo_d = quo_step;
        if (ctrl_i.last) begin
          den_d = quo_step;
        end
      end
      default: begin
      end
    endcase
  end

  assign num_s = neg_q ? -signed'({1'b0, mag_q}) : signed'({1'b0, mag_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_LOAD) begin
      na_q <= signed'(num_a_i);
      nb_q <= signed'(num_b_i);
      da_q <= (den_a_i == '0) ? DW'(1) : den_a_i;
      db_q <= (den_b_i == '0) ? DW'(1) : den_b_i;
    end
    prod_q <= prod;
    if (ctrl_i.op == OP_MUL_B) begin
      acc_q <= prod_q;
    end else if (ctrl_i.op == OP_MUL_C) begin
      acc_q <= acc_q + prod_q;
    end
    a_q   <= a_d;
    b_q   <= b_d;
    mag_q <= mag_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    if (ctrl_i.op == OP_OUT) begin
      sum_num_q <= NumOutW'(num_s);
      sum_den_q <= DenOutW'(den_q);
    end
  end

  assign sum_num_o = sum_num_q;
  assign sum_den_o = sum_den_q;

endmodule
`default_nettype wire

FILE: rtl/fadd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fadd_ctrl
// Sequencer: steps the datapath through multiply, gcd and divide phases (a
// zero sum skips straight to the output) and owns both handshakes.
// ----------------------------------------------------------------------------
module fadd_ctrl #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire fadd_pkg::stat_t stat_i,
  output fadd_pkg::ctrl_t      ctrl_o
);
  import fadd_pkg::*;

  localparam int MW = 2 * OPERAND_WIDTH - 1;
  localparam int CW = $clog2(MW);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          last, out_free;

  assign last     = (cnt_q == CW'(MW - 1));
  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_MUL_A;
      ST_MUL_A:   state_d = ST_MUL_B;
      ST_MUL_B:   state_d = ST_MUL_C;
      ST_MUL_C:   state_d = ST_ABS;
      ST_ABS:     state_d = stat_i.zero ? ST_FIN : ST_STRIP;
      ST_STRIP:   if (stat_i.strip_done) state_d = ST_GCD;
      ST_GCD:     if (stat_i.gcd_done) state_d = ST_DIV_NUM;
      ST_DIV_NUM: if (last) state_d = ST_DIV_DEN;
      ST_DIV_DEN: if (last) state_d = ST_FIN;
      ST_FIN:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.last = last;
    in_ready_o  = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE:    ctrl_o.op = in_valid_i ? OP_LOAD : OP_IDLE;
      ST_MUL_A:   ctrl_o.op = OP_MUL_A;
      ST_MUL_B:   ctrl_o.op = OP_MUL_B;
      ST_MUL_C:   ctrl_o.op = OP_MUL_C;
      ST_ABS:     ctrl_o.op = OP_ABS;
      ST_STRIP:   ctrl_o.op = OP_STRIP;
      ST_GCD:     ctrl_o.op = OP_GCD;
      ST_DIV_NUM: ctrl_o.op = OP_DIV_NUM;
      ST_DIV_DEN: ctrl_o.op = OP_DIV_DEN;
      ST_FIN:     ctrl_o.op = out_free ? OP_OUT : OP_IDLE;
      default:    ctrl_o.op = OP_IDLE;
    endcase
  end

  always_comb begin
    if (state_q == ST_DIV_NUM || state_q == ST_DIV_DEN) begin
      cnt_d = last ? '0 : cnt_q + CW'(1);
    end else begin
      cnt_d = '0;
    end
    if (state_q == ST_FIN && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_MUL_A))
    else $error("accepted request did not start the multiply phase");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result shown without finishing a request");

  a_cnt_only_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (state_q == ST_DIV_NUM || state_q == ST_DIV_DEN))
    else $error("division counter running outside division");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !out_ready_i) |=> (state_q == ST_FIN))
    else $error("finished result overwrote an untaken result");
`endif

endmodule
`default_nettype wire

FILE: rtl/fraction_add_reduce_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fraction_add_reduce_top
// Adds two fractions and returns the sum reduced to lowest terms.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_ready_o carries num_a/den_a and num_b/den_b;
// output channel out_valid_o/out_ready_i returns sum_num/sum_den, one result
// per request, sign on the numerator, a zero sum given as 0/1.
// A request is taken only while the sequencer is idle. It uses the one
// multiplier for the cross products and the denominator product, forms the
// magnitude, strips common factors of two, runs the binary gcd on the shared
// subtractor, then the two restoring divisions on that same subtractor, and
// loads the output register. The gcd loop and the divisions dominate the
// time of a nonzero sum; a zero sum skips the strip, gcd and divisions.
// The output register holds a result until it is taken, and in_ready_o
// returns high as soon as the result is loaded, so a new request can start
// while the receiver stalls; a second result waits until the first is taken.
// Reset clears the sequencer and drops out_valid_o; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module fraction_add_reduce_top #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [OPERAND_WIDTH-1:0]      num_a_i,
  input  wire logic [OPERAND_WIDTH-2:0]      den_a_i,
  input  wire logic [OPERAND_WIDTH-1:0]      num_b_i,
  input  wire logic [OPERAND_WIDTH-2:0]      den_b_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [fadd_pkg::NumOutW-1:0]       sum_num_o,
  output logic [fadd_pkg::DenOutW-1:0]       sum_den_o
);
  import fadd_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  fadd_ctrl #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  fadd_dp #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .num_a_i  (num_a_i),
    .den_a_i  (den_a_i),
    .num_b_i  (num_b_i),
    .den_b_i  (den_b_i),
    .stat_o   (stat),
    .sum_num_o(sum_num_o),
    .sum_den_o(sum_den_o)
  );

endmodule
`default_nettype wire
